>>> hw/rtl/bitmap_font_glyph_renderer_core_assert.svh
// Assertion macros for the glyph renderer.
// Clocked concurrent checks with a synchronous reset disable; no other dependencies.
`ifndef BITMAP_FONT_GLYPH_RENDERER_CORE_ASSERT_SVH
`define BITMAP_FONT_GLYPH_RENDERER_CORE_ASSERT_SVH

// same-cycle implication
`define BFGR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfgr same-cycle check failed");

// next-cycle implication
`define BFGR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfgr next-cycle check failed");

`endif

>>> hw/rtl/bfgr_pkg.sv
// Shared types, codes, reset values and the row mask function of the glyph renderer.
// No dependencies.
package bfgr_pkg;

   localparam int FONT_WORDS_DEFAULT = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 32;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_DRAW    = 2'd1;
   localparam logic [1:0] FUNC_MEASURE = 2'd2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_ROWS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_CODE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_COUNT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACING      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_COLOR  = 3'd5;

   localparam logic        WIDE_ROWS_RST    = 1'b0;
   localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd8;
   localparam logic [7:0]  FIRST_CODE_RST   = 8'd32;
   localparam logic [8:0]  GLYPH_COUNT_RST  = 9'd96;
   localparam logic [7:0]  SPACING_RST      = 8'd1;
   localparam logic [23:0] PIXEL_COLOR_RST  = 24'hFFFFFF;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         char_code;
      logic               starts_string;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic [11:0]        load_addr;
      logic [15:0]        load_data;
   } req_type;

   typedef struct packed {
      logic               status;
      logic               is_row;
      logic signed [15:0] row_x;
      logic signed [15:0] row_y;
      logic [15:0]        row_mask;
      logic [23:0]        row_color;
      logic [4:0]         glyph_width;
      logic signed [15:0] next_x;
      logic signed [15:0] total_width;
      logic               last;
   } rsp_type;

   // mirror the row word into a left-aligned mask, then cut it to the glyph width
   function automatic logic [15:0] row_mask_of(logic [15:0] word, logic wide,
                                               logic [4:0] gw);
      logic [15:0] rev;
      logic [16:0] lim;
      for (int k = 0; k < 16; k++) begin
         if (wide) begin
            rev[k] = word[15-k];
         end else if (k < 8) begin
            rev[k] = word[7-k];
         end else begin
            rev[k] = 1'b0;
         end
      end
      lim = (17'd1 << gw) - 17'd1;
      return rev & lim[15:0];
   endfunction

endpackage

>>> hw/rtl/bitmap_font_glyph_renderer_core.sv
// Glyph renderer top level: font word memory, lookup sequencer, cursor and width state.
// Depends on bfgr_pkg and bitmap_font_glyph_renderer_core_assert.svh.
//
//  port group | direction | handshake                     | payload
//  req_*      | in        | start high, busy low          | req_item  (bfgr_pkg::req_type)
//  rsp_*      | out       | rsp_valid per result          | rsp_item  (bfgr_pkg::rsp_type)
//  csr_*      | in        | csr_wr_en, no wait            | csr_index, csr_wr_data
//
// Load and unused items stay in ST_IDLE; an out-of-font code stops in ST_LOOKUP; measure runs
// ST_LOOKUP, ST_WREAD, ST_WIDTH; draw adds an ST_ROWS step per row (none at height 0), with one font
// memory read per cycle (width word, then one row word per result). Results are registered. Reset
// clears cursor, width total and sequencer and restores the configuration reset values; the font
// memory is not cleared. The receiver cannot stall; rows of one glyph leave on consecutive cycles.
`include "bitmap_font_glyph_renderer_core_assert.svh"

module bitmap_font_glyph_renderer_core #(
   parameter int FONT_WORDS = bfgr_pkg::FONT_WORDS_DEFAULT,
   parameter int MAX_HEIGHT = bfgr_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bfgr_pkg::req_type                 req_item,
   output logic                              rsp_valid,
   output bfgr_pkg::rsp_type                 rsp_item,
   input  logic                              csr_wr_en,
   input  logic [bfgr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bfgr_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import bfgr_pkg::*;

   localparam int AW = $clog2(FONT_WORDS);
   localparam int RW = $clog2(MAX_HEIGHT + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOKUP = 3'd1;
   localparam logic [2:0] ST_WREAD  = 3'd2;
   localparam logic [2:0] ST_ROWS   = 3'd3;
   localparam logic [2:0] ST_WIDTH  = 3'd4;

   logic [15:0]   font_mem [FONT_WORDS];
   logic [15:0]   rd_data_ff;

   logic          wide_rows_ff;
   logic [5:0]    glyph_height_ff;
   logic [7:0]    first_code_ff;
   logic [8:0]    glyph_count_ff;
   logic [7:0]    spacing_ff;
   logic [23:0]   pixel_color_ff;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    func_ff, func_in;
   logic [7:0]    code_ff, code_in;
   logic [15:0]   cursor_x_ff, cursor_x_in;
   logic [15:0]   cursor_y_ff, cursor_y_in;
   logic [15:0]   width_total_ff, width_total_in;
   logic [4:0]    gw_ff, gw_in;
   logic [15:0]   nx_ff, nx_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          accept;
   logic          load_accept;
   logic [5:0]    height_cap;
   logic [7:0]    glyph_idx;
   logic          code_err;
   logic [15:0]   base_word;
   logic [15:0]   raw_w;
   logic [4:0]    sym_w;
   logic [4:0]    gw_now;
   logic [15:0]   nx_now;
   logic [16:0]   width_sum;
   logic          row_last;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign load_accept = accept && (req_item.func == FUNC_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_ff;

   assign height_cap = (glyph_height_ff > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : glyph_height_ff;
   assign glyph_idx  = code_ff - first_code_ff;
   assign code_err   = (code_ff < first_code_ff) || ({1'b0, glyph_idx} >= glyph_count_ff);
   assign base_word  = 16'(glyph_idx) * 16'({1'b0, glyph_height_ff} + 7'd1);
   assign raw_w      = wide_rows_ff ? rd_data_ff : {8'd0, rd_data_ff[7:0]};
   assign sym_w      = wide_rows_ff ? 5'd16 : 5'd8;
   assign gw_now     = (raw_w > 16'(sym_w)) ? sym_w : raw_w[4:0];
   assign nx_now     = cursor_x_ff + 16'(gw_now) + 16'(spacing_ff);
   assign width_sum  = {1'b0, width_total_ff} + 17'(gw_now) + 17'(spacing_ff);
   assign row_last   = (6'(row_ff) == (height_cap - 6'd1));

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      code_in        = code_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      width_total_in = width_total_ff;
      gw_in          = gw_ff;
      nx_in          = nx_ff;
      row_in         = row_ff;
      addr_in        = addr_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = '0;
      rsp_in.next_x      = cursor_x_ff;
      rsp_in.total_width = width_total_ff;
      rsp_in.last        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = req_item.func;
               code_in = req_item.char_code;
               if (req_item.func == FUNC_DRAW) begin
                  state_in = ST_LOOKUP;
                  if (req_item.starts_string) begin
                     cursor_x_in = req_item.start_x;
                     cursor_y_in = req_item.start_y;
                  end
               end else if (req_item.func == FUNC_MEASURE) begin
                  state_in = ST_LOOKUP;
                  if (req_item.starts_string) begin
                     width_total_in = '0;
                  end
               end
            end
         end
         ST_LOOKUP: begin
            if (code_err) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               addr_in  = AW'(base_word);
               state_in = ST_WREAD;
            end
         end
         ST_WREAD: begin
            addr_in  = addr_ff + AW'(1);
            state_in = ST_WIDTH;
         end
         ST_WIDTH: begin
            addr_in = addr_ff + AW'(1);
            gw_in   = gw_now;
            nx_in   = nx_now;
            row_in  = '0;
            if (func_ff == FUNC_MEASURE) begin
               width_total_in     = (width_sum > 17'd32767) ? 16'h7FFF : width_sum[15:0];
               rsp_valid_in       = 1'b1;
               rsp_in.glyph_width = gw_now;
               rsp_in.total_width = width_total_in;
               state_in           = ST_IDLE;
            end else if (height_cap == 6'd0) begin
               rsp_valid_in       = 1'b1;
               rsp_in.glyph_width = gw_now;
               rsp_in.next_x      = nx_now;
               cursor_x_in        = nx_now;
               state_in           = ST_IDLE;
            end else begin
               state_in = ST_ROWS;
            end
         end
         ST_ROWS: begin
            addr_in            = addr_ff + AW'(1);
            row_in             = row_ff + RW'(1);
            rsp_valid_in       = 1'b1;
            rsp_in.is_row      = 1'b1;
            rsp_in.row_x       = cursor_x_ff;
            rsp_in.row_y       = cursor_y_ff + 16'(row_ff);
            rsp_in.row_mask    = row_mask_of(rd_data_ff, wide_rows_ff, gw_ff);
            rsp_in.row_color   = pixel_color_ff;
            rsp_in.glyph_width = gw_ff;
            rsp_in.next_x      = nx_ff;
            rsp_in.last        = row_last;
            if (row_last) begin
               cursor_x_in = nx_ff;
               row_in      = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cursor_x_ff    <= '0;
         cursor_y_ff    <= '0;
         width_total_ff <= '0;
         row_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
         width_total_ff <= width_total_in;
         row_ff         <= row_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      code_ff <= code_in;
      gw_ff   <= gw_in;
      nx_ff   <= nx_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (load_accept) begin
         font_mem[AW'(req_item.load_addr)] <= req_item.load_data;
      end
      rd_data_ff <= font_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_rows_ff    <= WIDE_ROWS_RST;
         glyph_height_ff <= GLYPH_HEIGHT_RST;
         first_code_ff   <= FIRST_CODE_RST;
         glyph_count_ff  <= GLYPH_COUNT_RST;
         spacing_ff      <= SPACING_RST;
         pixel_color_ff  <= PIXEL_COLOR_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDE_ROWS:    wide_rows_ff    <= csr_wr_data[0];
            CSR_GLYPH_HEIGHT: glyph_height_ff <= csr_wr_data[5:0];
            CSR_FIRST_CODE:   first_code_ff   <= csr_wr_data[7:0];
            CSR_GLYPH_COUNT:  glyph_count_ff  <= csr_wr_data[8:0];
            CSR_SPACING:      spacing_ff      <= csr_wr_data[7:0];
            CSR_PIXEL_COLOR:  pixel_color_ff  <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   `BFGR_ASSERT_NXT(a_rows_back_to_back, clock, reset, rsp_valid && !rsp_item.last, rsp_valid)
   `BFGR_ASSERT_IMP(a_nonrow_is_last, clock, reset, rsp_valid && !rsp_item.is_row, rsp_item.last)
   `BFGR_ASSERT_IMP(a_error_no_row, clock, reset, rsp_valid && rsp_item.status, !rsp_item.is_row && (rsp_item.glyph_width == 5'd0))
   `BFGR_ASSERT_NXT(a_lookup_goes_busy, clock, reset, accept && ((req_item.func == FUNC_DRAW) || (req_item.func == FUNC_MEASURE)), busy)
   `BFGR_ASSERT_IMP(a_row_in_range, clock, reset, state_ff == ST_ROWS, 6'(row_ff) < height_cap)

endmodule

>>> tb/bitmap_font_glyph_renderer_core_test.sv
// Self-checking bench for the bitmap font glyph renderer: directed table, then random phases.
// Expected rows come from a behavioral font renderer kept in step with each accepted transaction.
// Depends on bfgr_pkg and bitmap_font_glyph_renderer_core.
module bitmap_font_glyph_renderer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bfgr_pkg::*;

   localparam int FONT_WORDS    = FONT_WORDS_DEFAULT;
   localparam int MAX_ROWS      = MAX_HEIGHT_DEFAULT;
   localparam int DRAIN_CYCLES  = 40;
   localparam int QUIET_LIMIT   = 1000;
   localparam int PRINT_CAP     = 40;
   localparam int DIRECTED_ROWS = 15;
   localparam int WIDE_FROM     = 5;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      req_type item;
      bit      fixed;
      bit      fixed_out;
      rsp_type result;
   } step_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_item;
   logic                   rsp_valid;
   rsp_type                rsp_item;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   // font renderer state
   logic [15:0]        font_mem [FONT_WORDS];
   bit                 word_loaded [FONT_WORDS];
   logic signed [15:0] cur_x;
   logic signed [15:0] cur_y;
   int                 width_sum;
   logic               cfg_wide;
   logic [5:0]         cfg_height;
   logic [7:0]         cfg_first;
   logic [8:0]         cfg_count;
   logic [7:0]         cfg_spacing;
   logic [23:0]        cfg_color;

   rsp_type fresh_rows [$];
   rsp_type rows_due [$];

   int gap_pct;
   int mismatches;
   int n_loads, n_draws, n_measures, n_ignored;
   int rows_checked, misses_checked;

   step_type directed [DIRECTED_ROWS] = '{
      '{{FUNC_DRAW, 8'd0, 1'b1, 16'h8000, 16'h7FFF, 12'h000, 16'h0000}, 1'b1, 1'b1,
        {1'b1, 1'b0, 16'h0, 16'h0, 16'h0, 24'h0, 5'd0, 16'h8000, 16'h0, 1'b1}},
      '{{FUNC_MEASURE, 8'd31, 1'b0, 16'h0000, 16'h0000, 12'h000, 16'h0000}, 1'b1, 1'b1,
        {1'b1, 1'b0, 16'h0, 16'h0, 16'h0, 24'h0, 5'd0, 16'h8000, 16'h0, 1'b1}},
      '{{FUNC_DRAW, 8'd128, 1'b0, 16'h0000, 16'h0000, 12'h000, 16'h0000}, 1'b1, 1'b1,
        {1'b1, 1'b0, 16'h0, 16'h0, 16'h0, 24'h0, 5'd0, 16'h8000, 16'h0, 1'b1}},
      '{{FUNC_MEASURE, 8'd255, 1'b1, 16'h0000, 16'h0000, 12'h000, 16'h0000}, 1'b1, 1'b1,
        {1'b1, 1'b0, 16'h0, 16'h0, 16'h0, 24'h0, 5'd0, 16'h8000, 16'h0, 1'b1}},
      '{{FUNC_UNUSED, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 12'hFFF, 16'hFFFF}, 1'b1, 1'b0,
        112'd0},
      '{{FUNC_LOAD, 8'd0, 1'b0, 16'h0000, 16'h0000, 12'd0, 16'hFFFF}, 1'b0, 1'b0, 112'd0},
      '{{FUNC_LOAD, 8'd0, 1'b0, 16'h0000, 16'h0000, 12'd1, 16'h8001}, 1'b0, 1'b0, 112'd0},
      '{{FUNC_LOAD, 8'd0, 1'b0, 16'h0000, 16'h0000, 12'd510, 16'h0005}, 1'b0, 1'b0, 112'd0},
      '{{FUNC_LOAD, 8'd0, 1'b0, 16'h0000, 16'h0000, 12'd511, 16'hFFFF}, 1'b0, 1'b0, 112'd0},
      '{{FUNC_LOAD, 8'd0, 1'b0, 16'h0000, 16'h0000, 12'hFFF, 16'h0000}, 1'b0, 1'b0, 112'd0},
      '{{FUNC_DRAW, 8'd0, 1'b1, 16'h7FFF, 16'h8000, 12'h000, 16'h0000}, 1'b0, 1'b0, 112'd0},
      '{{FUNC_DRAW, 8'd255, 1'b0, 16'h0000, 16'h0000, 12'h000, 16'h0000}, 1'b0, 1'b0, 112'd0},
      '{{FUNC_MEASURE, 8'd0, 1'b1, 16'h0000, 16'h0000, 12'h000, 16'h0000}, 1'b0, 1'b0,
        112'd0},
      '{{FUNC_MEASURE, 8'd255, 1'b0, 16'h0000, 16'h0000, 12'h000, 16'h0000}, 1'b0, 1'b0,
        112'd0},
      '{{FUNC_DRAW, 8'd0, 1'b0, 16'h0000, 16'h0000, 12'h000, 16'h0000}, 1'b0, 1'b0, 112'd0}
   };

   bitmap_font_glyph_renderer_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic void render_char(req_type r);
      int          idx, base, rows, sym, t;
      logic [15:0] raw, word, nx, mask;
      logic [4:0]  gw;
      rsp_type     res;
      fresh_rows.delete();
      case (r.func)
         FUNC_LOAD: begin
            font_mem[r.load_addr] = r.load_data;
            word_loaded[r.load_addr] = 1'b1;
            n_loads++;
            return;
         end
         FUNC_DRAW: n_draws++;
         FUNC_MEASURE: n_measures++;
         default: begin
            n_ignored++;
            return;
         end
      endcase
      if (r.starts_string) begin
         if (r.func == FUNC_DRAW) begin
            cur_x = r.start_x;
            cur_y = r.start_y;
         end else begin
            width_sum = 0;
         end
      end
      res = '0;
      res.last = 1'b1;
      res.next_x = cur_x;
      res.total_width = width_sum[15:0];
      idx = int'(r.char_code) - int'(cfg_first);
      if (idx < 0 || idx >= int'(cfg_count)) begin
         res.status = 1'b1;
         fresh_rows.push_back(res);
         return;
      end
      sym = cfg_wide ? 16 : 8;
      rows = int'(cfg_height);
      if (rows > MAX_ROWS) rows = MAX_ROWS;
      base = idx * (int'(cfg_height) + 1);
      raw = font_mem[base % FONT_WORDS];
      if (!cfg_wide) raw[15:8] = '0;
      gw = (int'(raw) > sym) ? 5'(sym) : raw[4:0];
      res.glyph_width = gw;
      if (r.func == FUNC_MEASURE) begin
         t = width_sum + int'(gw) + int'(cfg_spacing);
         width_sum = (t > 32767) ? 32767 : t;
         res.total_width = width_sum[15:0];
         fresh_rows.push_back(res);
         return;
      end
      nx = cur_x + 16'(gw) + 16'(cfg_spacing);
      res.next_x = nx;
      if (rows == 0) begin
         fresh_rows.push_back(res);
      end
      for (int i = 0; i < rows; i++) begin
         word = font_mem[(base + 1 + i) % FONT_WORDS];
         mask = '0;
         for (int k = 0; k < int'(gw); k++) mask[k] = word[sym - 1 - k];
         res.is_row = 1'b1;
         res.row_x = cur_x;
         res.row_y = cur_y + 16'(i);
         res.row_mask = mask;
         res.row_color = cfg_color;
         res.last = (i == rows - 1);
         fresh_rows.push_back(res);
      end
      cur_x = nx;
   endfunction

   function automatic req_type scatter();
      req_type r;
      r.func = 2'($urandom);
      r.char_code = 8'($urandom);
      r.starts_string = 1'($urandom);
      r.start_x = 16'($urandom);
      r.start_y = 16'($urandom);
      r.load_addr = 12'($urandom);
      r.load_data = 16'($urandom);
      return r;
   endfunction

   task automatic report(string msg);
      if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic issue(req_type r, bit fixed = 1'b0, bit fixed_out = 1'b0,
                        rsp_type fixed_res = '0);
      if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(13, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      render_char(r);
      if (fixed) begin
         if (fixed_out) rows_due.push_back(fixed_res);
      end else begin
         foreach (fresh_rows[i]) rows_due.push_back(fresh_rows[i]);
      end
   endtask

   // load any glyph word of this code that has never been written
   task automatic ready_glyph(logic [7:0] code);
      int      idx, base, rows, a;
      req_type r;
      idx = int'(code) - int'(cfg_first);
      if (idx < 0 || idx >= int'(cfg_count)) return;
      rows = int'(cfg_height);
      if (rows > MAX_ROWS) rows = MAX_ROWS;
      base = idx * (int'(cfg_height) + 1);
      for (int i = 0; i <= rows; i++) begin
         a = (base + i) % FONT_WORDS;
         if (!word_loaded[a]) begin
            r = scatter();
            r.func = FUNC_LOAD;
            r.load_addr = 12'(a);
            if (i == 0) begin
               case ($urandom_range(3, 0))
                  0, 1: r.load_data = 16'($urandom_range(17, 0));
                  2: r.load_data = 16'($urandom);
                  default: r.load_data = {8'($urandom), 8'($urandom_range(9, 0))};
               endcase
            end
            issue(r);
         end
      end
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_WIDE_ROWS: cfg_wide = data[0];
         CSR_GLYPH_HEIGHT: cfg_height = data[5:0];
         CSR_FIRST_CODE: cfg_first = data[7:0];
         CSR_GLYPH_COUNT: cfg_count = data[8:0];
         CSR_SPACING: cfg_spacing = data[7:0];
         CSR_PIXEL_COLOR: cfg_color = data[23:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic wide, logic [5:0] height, logic [7:0] first,
                                logic [8:0] count, logic [7:0] spacing, logic [23:0] color);
      write_csr(CSR_WIDE_ROWS, CSR_DATA_W'(wide));
      write_csr(CSR_GLYPH_HEIGHT, CSR_DATA_W'(height));
      write_csr(CSR_FIRST_CODE, CSR_DATA_W'(first));
      write_csr(CSR_GLYPH_COUNT, CSR_DATA_W'(count));
      write_csr(CSR_SPACING, CSR_DATA_W'(spacing));
      write_csr(CSR_PIXEL_COLOR, color);
      csr_wr_en <= 1'b0;
   endtask

   // hold off until every pending row is back and the block has gone quiet
   task automatic settle();
      start <= 1'b0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int items, int pool_size, int measure_pct, int starts_pct,
                            int idle_pct);
      logic [7:0] pool [8];
      int         hi, roll;
      req_type    r;
      gap_pct = idle_pct;
      hi = int'(cfg_first) + int'(cfg_count) - 1;
      if (hi > 255) hi = 255;
      for (int i = 0; i < pool_size; i++) begin
         if (hi < int'(cfg_first)) pool[i] = 8'($urandom);
         else if (i == 0) pool[i] = cfg_first;
         else if (i == 1) pool[i] = 8'(hi);
         else pool[i] = 8'($urandom_range(hi, int'(cfg_first)));
      end
      for (int n = 0; n < items; n++) begin
         r = scatter();
         roll = $urandom_range(99, 0);
         if (roll < 6) begin
            r.func = FUNC_LOAD;
         end else if (roll < 9) begin
            r.func = FUNC_UNUSED;
         end else begin
            r.func = ($urandom_range(99, 0) < measure_pct) ? FUNC_MEASURE : FUNC_DRAW;
            r.starts_string = ($urandom_range(99, 0) < starts_pct);
            if (roll >= 24) r.char_code = pool[$urandom_range(pool_size - 1, 0)];
            ready_glyph(r.char_code);
         end
         issue(r);
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type due;
      if (!reset && rsp_valid) begin
         if (rows_due.size() == 0) begin
            report($sformatf("result with nothing pending, next_x %0h", rsp_item.next_x));
         end else begin
            due = rows_due.pop_front();
            check_field("status", rsp_item.status, due.status);
            check_field("is_row", rsp_item.is_row, due.is_row);
            check_field("row_x", rsp_item.row_x, due.row_x);
            check_field("row_y", rsp_item.row_y, due.row_y);
            check_field("row_mask", rsp_item.row_mask, due.row_mask);
            check_field("row_color", rsp_item.row_color, due.row_color);
            check_field("glyph_width", rsp_item.glyph_width, due.glyph_width);
            check_field("next_x", rsp_item.next_x, due.next_x);
            check_field("total_width", rsp_item.total_width, due.total_width);
            check_field("last", rsp_item.last, due.last);
            if (due.is_row) rows_checked++;
            if (due.status) misses_checked++;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || rsp_valid || (start && !busy) || csr_wr_en) quiet = 0;
         else quiet++;
      end
      $display("[bitmap_font_glyph_renderer_core] ERROR");
      $finish;
   end

   initial begin : stimulus
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      cur_x = '0;
      cur_y = '0;
      width_sum = 0;
      cfg_wide = WIDE_ROWS_RST;
      cfg_height = GLYPH_HEIGHT_RST;
      cfg_first = FIRST_CODE_RST;
      cfg_count = GLYPH_COUNT_RST;
      cfg_spacing = SPACING_RST;
      cfg_color = PIXEL_COLOR_RST;
      foreach (word_loaded[i]) word_loaded[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct = 25;
      foreach (directed[i]) begin
         if (i == WIDE_FROM) begin
            settle();
            load_settings(1'b1, 6'd1, 8'd0, 9'd256, 8'd255, 24'h000000);
         end
         issue(directed[i].item, directed[i].fixed, directed[i].fixed_out,
               directed[i].result);
      end

      settle();
      load_settings(1'b0, 6'd8, 8'd32, 9'd96, 8'd1, 24'($urandom));
      run_phase(14, 2, 30, 20, 30);
      settle();
      load_settings(1'b1, 6'd32, 8'd200, 9'd56, 8'd0, 24'hFFFFFF);
      run_phase(6, 1, 30, 25, 20);
      settle();
      load_settings(1'b0, 6'd0, 8'd0, 9'd256, 8'd7, 24'($urandom));
      run_phase(16, 6, 40, 20, 40);
      settle();
      load_settings(1'b1, 6'd63, 8'd0, 9'd511, 8'd3, 24'($urandom));
      run_phase(4, 1, 30, 20, 15);
      settle();
      load_settings(1'b1, 6'd1, 8'd0, 9'd256, 8'd255, 24'h000000);
      run_phase(30, 8, 100, 0, 10);
      settle();
      load_settings(1'b0, 6'd5, 8'd255, 9'd1, 8'd2, 24'($urandom));
      run_phase(12, 1, 30, 30, 30);
      settle();
      load_settings(1'b0, 6'd3, 8'd100, 9'd0, 8'd9, 24'($urandom));
      run_phase(8, 2, 50, 30, 20);
      settle();
      load_settings(1'($urandom), 6'($urandom_range(12, 1)), 8'($urandom),
                    9'($urandom_range(256, 0)), 8'($urandom), 24'($urandom));
      run_phase(16, 3, 30, 25, 0);
      settle();

      $display("covered %0d draws, %0d measures, %0d font loads, %0d ignored transactions",
               n_draws, n_measures, n_loads, n_ignored);
      $display("checked %0d glyph rows and %0d out-of-font results, %0d mismatches",
               rows_checked, misses_checked, mismatches);
      if (mismatches == 0) begin
         $display("[bitmap_font_glyph_renderer_core] OK");
      end else begin
         $display("[bitmap_font_glyph_renderer_core] ERROR");
      end
      $finish;
   end

endmodule
